// ----- sv/lpws_pkg.sv -----
// shared types and constants for the led pulse width serializer
`default_nettype none

package lpws_pkg;

  localparam int COLOR_BITS = 8;
  localparam int PIXEL_BITS = 3 * COLOR_BITS;
  localparam int BITS_W     = $clog2(PIXEL_BITS + 1);
  localparam int COUNT_W    = 16;
  localparam int PULSE_W    = 8;
  localparam int CFG_IDX_W  = 3;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_LOW = 3'd4;

  // reset values of the timing registers
  localparam logic [PULSE_W-1:0] ONE_HIGH_RST  = 8'd24;
  localparam logic [PULSE_W-1:0] ONE_LOW_RST   = 8'd10;
  localparam logic [PULSE_W-1:0] ZERO_HIGH_RST = 8'd8;
  localparam logic [PULSE_W-1:0] ZERO_LOW_RST  = 8'd28;
  localparam logic [COUNT_W-1:0] LATCH_LOW_RST = 16'd2000;

  // line phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;
  localparam logic [1:0] PH_LATCH = 2'd3;

  // item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef struct packed {
    logic [PULSE_W-1:0] one_high;
    logic [PULSE_W-1:0] one_low;
    logic [PULSE_W-1:0] zero_high;
    logic [PULSE_W-1:0] zero_low;
    logic [COUNT_W-1:0] latch_low;
  } lpws_cfg_t;

  typedef struct packed {
    logic                  kind;
    logic [PIXEL_BITS-1:0] pixel;       // green in the top byte, blue in the bottom
    logic                  final_pixel;
  } lpws_item_t;

  typedef struct packed {
    logic underrun;
    logic pixel_dropped;
    logic sending;
    logic can_take_pixel;
    logic line_level;
  } lpws_result_t;

  // a tick count of zero behaves as one
  function automatic logic [COUNT_W-1:0] at_least_one(input logic [COUNT_W-1:0] v);
    return (v == '0) ? COUNT_W'(1) : v;
  endfunction

endpackage

`default_nettype wire

// ----- sv/lpws_cfg.sv -----
// timing register file written through the configuration channel
`default_nettype none

module lpws_cfg
  import lpws_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COUNT_W-1:0]   cfg_data,
  output      lpws_cfg_t            cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.one_high  <= ONE_HIGH_RST;
      cfg.one_low   <= ONE_LOW_RST;
      cfg.zero_high <= ZERO_HIGH_RST;
      cfg.zero_low  <= ZERO_LOW_RST;
      cfg.latch_low <= LATCH_LOW_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ONE_HIGH:  cfg.one_high  <= cfg_data[PULSE_W-1:0];
        REG_ONE_LOW:   cfg.one_low   <= cfg_data[PULSE_W-1:0];
        REG_ZERO_HIGH: cfg.zero_high <= cfg_data[PULSE_W-1:0];
        REG_ZERO_LOW:  cfg.zero_low  <= cfg_data[PULSE_W-1:0];
        REG_LATCH_LOW: cfg.latch_low <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/lpws_core.sv -----
// serializer state and the per-item step logic
`default_nettype none

module lpws_core
  import lpws_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire lpws_item_t item,
  input  wire lpws_cfg_t  cfg,
  output      lpws_result_t result
);

  logic [PIXEL_BITS-1:0] shift_bits, shift_bits_next;
  logic [BITS_W-1:0]     bits_left, bits_left_next;
  logic [1:0]            phase, phase_next;
  logic [COUNT_W-1:0]    phase_count, phase_count_next;
  logic [PIXEL_BITS-1:0] held_pixel, held_pixel_next;
  logic                  held_valid, held_valid_next;
  logic                  held_final, held_final_next;
  logic                  current_final, current_final_next;

  logic [COUNT_W-1:0]    count_dec;
  logic [BITS_W-1:0]     bits_dec;
  logic [COUNT_W-1:0]    load_count;
  logic [COUNT_W-1:0]    low_count;
  logic [COUNT_W-1:0]    next_bit_count;
  logic                  dropped;

  assign count_dec = phase_count - COUNT_W'(1);
  assign bits_dec  = bits_left - BITS_W'(1);

  // first high pulse of a freshly loaded pixel
  assign load_count = at_least_one(COUNT_W'(held_pixel[PIXEL_BITS-1] ? cfg.one_high
                                                                     : cfg.zero_high));
  // low pulse of the bit in flight
  assign low_count = at_least_one(COUNT_W'(shift_bits[PIXEL_BITS-1] ? cfg.one_low
                                                                    : cfg.zero_low));
  // high pulse of the following bit, taken from the shifted word
  assign next_bit_count = at_least_one(COUNT_W'(shift_bits[PIXEL_BITS-2] ? cfg.one_high
                                                                         : cfg.zero_high));

  always_comb begin
    shift_bits_next    = shift_bits;
    bits_left_next     = bits_left;
    phase_next         = phase;
    phase_count_next   = phase_count;
    held_pixel_next    = held_pixel;
    held_valid_next    = held_valid;
    held_final_next    = held_final;
    current_final_next = current_final;
    dropped            = 1'b0;

    if (item.kind == KIND_PIXEL) begin
      if (held_valid) begin
        dropped = 1'b1;
      end else begin
        held_pixel_next = item.pixel;
        held_final_next = item.final_pixel;
        held_valid_next = 1'b1;
      end
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (held_valid) begin
            shift_bits_next    = held_pixel;
            current_final_next = held_final;
            held_valid_next    = 1'b0;
            bits_left_next     = BITS_W'(PIXEL_BITS);
            phase_next         = PH_HIGH;
            phase_count_next   = load_count;
          end
        end
        PH_HIGH: begin
          phase_count_next = count_dec;
          if (count_dec == '0) begin
            phase_next       = PH_LOW;
            phase_count_next = low_count;
          end
        end
        PH_LATCH: begin
          phase_count_next = count_dec;
          if (count_dec == '0) begin
            phase_next = PH_IDLE;
          end
        end
        PH_LOW: begin
          if (bits_left == '0) begin
            // underrun wait at a pixel boundary
            if (held_valid) begin
              shift_bits_next    = held_pixel;
              current_final_next = held_final;
              held_valid_next    = 1'b0;
              bits_left_next     = BITS_W'(PIXEL_BITS);
              phase_next         = PH_HIGH;
              phase_count_next   = load_count;
            end
          end else begin
            phase_count_next = count_dec;
            if (count_dec == '0) begin
              shift_bits_next = {shift_bits[PIXEL_BITS-2:0], 1'b0};
              bits_left_next  = bits_dec;
              if (bits_dec != '0) begin
                phase_next       = PH_HIGH;
                phase_count_next = next_bit_count;
              end else if (current_final) begin
                phase_next       = PH_LATCH;
                phase_count_next = at_least_one(cfg.latch_low);
              end else if (held_valid) begin
                shift_bits_next    = held_pixel;
                current_final_next = held_final;
                held_valid_next    = 1'b0;
                bits_left_next     = BITS_W'(PIXEL_BITS);
                phase_next         = PH_HIGH;
                phase_count_next   = load_count;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result.line_level     = (phase == PH_HIGH);
    result.sending        = (phase != PH_IDLE);
    result.pixel_dropped  = dropped;
    result.can_take_pixel = !held_valid_next;
    result.underrun       = (phase_next == PH_LOW) && (bits_left_next == '0) &&
                            !held_valid_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits    <= '0;
      bits_left     <= '0;
      phase         <= PH_IDLE;
      phase_count   <= '0;
      held_valid    <= 1'b0;
      held_final    <= 1'b0;
      current_final <= 1'b0;
    end else if (step) begin
      shift_bits    <= shift_bits_next;
      bits_left     <= bits_left_next;
      phase         <= phase_next;
      phase_count   <= phase_count_next;
      held_valid    <= held_valid_next;
      held_final    <= held_final_next;
      current_final <= current_final_next;
    end
  end

  // pixel store is only read while held_valid is set
  always_ff @(posedge clk) begin
    if (step) begin
      held_pixel <= held_pixel_next;
    end
  end

endmodule

`default_nettype wire

// ----- sv/led_pulse_width_serializer.sv -----
// top level of the one-wire led strip pulse width serializer
`default_nettype none

// Pulse width serializer for a one-wire LED strip. Each input transfer is
// either a pixel offer (s_tuser low, green/red/blue in s_tdata, s_tlast marks
// the last pixel of the frame) or one time tick (s_tuser high). Every input
// transfer yields exactly one result transfer carrying the line level of that
// tick and status flags. Pixels are sent green, red, blue, each byte msb first;
// a one bit is one_high_ticks high then one_low_ticks low, a zero bit uses the
// zero counts, and after the last pixel the line stays low for latch_low_ticks.
// A one-pixel holding register keeps the next pixel; an offer while it is full
// is dropped and flagged. Throughput is one transfer per clock while the output
// is not stalled: an input register feeds the step logic and its state registers,
// whose result goes into an output register, so each item passes the input and
// output registers and, with m_tready held high, a new item is taken every cycle.
// Configuration registers (index 0 to 4: one_high, one_low, zero_high,
// zero_low, latch_low) are written through the cfg channel, which is always
// ready, and should be written only while idle.

module led_pulse_width_serializer
  import lpws_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // input stream
  input  wire logic                 s_tvalid,
  output      logic                 s_tready,
  input  wire logic [23:0]          s_tdata,   // green [7:0], red [15:8], blue [23:16]
  input  wire logic                 s_tuser,   // kind: 0 pixel offer, 1 time tick
  input  wire logic                 s_tlast,   // final_pixel
  // result stream
  output      logic                 m_tvalid,
  input  wire logic                 m_tready,
  output      logic [7:0]           m_tdata,   // line_level, can_take_pixel, sending,
                                               // pixel_dropped, underrun, zero pad
  // configuration writes
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COUNT_W-1:0]   cfg_data
);

  lpws_cfg_t    cfg;
  lpws_item_t   in_item;
  logic         in_valid;
  logic         advance;
  lpws_result_t result;

  // an item moves through the step logic when the output slot is free or drains
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.kind        <= s_tuser;
      in_item.pixel       <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
      in_item.final_pixel <= s_tlast;
    end
  end

  lpws_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lpws_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {3'b000, result.underrun, result.pixel_dropped, result.sending,
                  result.can_take_pixel, result.line_level};
    end
  end

endmodule

`default_nettype wire

// ----- sv/lpws_checker.sv -----
// port level checks for the serializer and their binding
`default_nettype none

module lpws_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  // a dropped offer means the holding register stays full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[3] |-> !m_tdata[1])
    else $error("dropped pixel while holding register empty");

  // an underrun wait is inside a frame with nothing held
  a_underrun: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4] |-> m_tdata[2] && m_tdata[1])
    else $error("underrun outside a frame or with a pixel held");

  // the line is only driven high while sending
  a_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> m_tdata[2])
    else $error("line high while idle");

endmodule

bind led_pulse_width_serializer lpws_checker u_lpws_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
